/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/ftta_pkg.sv */
// Shared constants and helpers for the flow tree ordering and accumulation block.
// No dependencies.
package ftta_pkg;

  localparam int MAX_CELLS = 1024;
  localparam int IDX_W     = $clog2(MAX_CELLS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int DS_W      = 11;
  localparam int OWN_W     = 32;
  localparam int AREA_W    = 48;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Saturating add of two accumulated areas.
  function automatic logic [AREA_W-1:0] sat_add(input logic [AREA_W-1:0] a,
                                                input logic [AREA_W-1:0] b);
    logic [AREA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AREA_W] ? {AREA_W{1'b1}} : s[AREA_W-1:0];
  endfunction

endpackage

/* rtl/flow_tree_topo_accumulate.sv */
// Top level: upstream-first ordering of a flow tree and area accumulation.
// Uses ftta_pkg and assert_macros.svh; holds five single-port-read memories.
//
//   channel   handshake          payload
//   input     start / busy       in_op, in_cell_index, in_downstream, in_cell_area
//   result    out_strobe         out_order_entry, out_accumulated_area,
//                                out_ordered_total, out_cycle_found
//   config    cfg_we             cfg_wdata (cell_count)
//
// Load and read transactions leave busy low and can follow back to back;
// a read result appears on the cycle after acceptance.
// A run keeps busy high through the clear, count, seed, Kahn and accumulate passes
// over n active cells; one registered read port per memory sets the steps of each pass.
// The in-degree memory is cleared by the run's first pass; no pass after reset.
// Synchronous active-low reset; the result receiver cannot stall.
`include "assert_macros.svh"

module flow_tree_topo_accumulate (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_op,
  input  logic [ftta_pkg::IDX_W-1:0]  in_cell_index,
  input  logic [ftta_pkg::DS_W-1:0]   in_downstream,
  input  logic [ftta_pkg::OWN_W-1:0]  in_cell_area,
  output logic                        out_strobe,
  output logic [ftta_pkg::IDX_W-1:0]  out_order_entry,
  output logic [ftta_pkg::AREA_W-1:0] out_accumulated_area,
  output logic [ftta_pkg::CNT_W-1:0]  out_ordered_total,
  output logic                        out_cycle_found,
  input  logic                        cfg_we,
  input  logic [ftta_pkg::CNT_W-1:0]  cfg_wdata
);

  localparam int IDX_W  = ftta_pkg::IDX_W;
  localparam int CNT_W  = ftta_pkg::CNT_W;
  localparam int DS_W   = ftta_pkg::DS_W;
  localparam int OWN_W  = ftta_pkg::OWN_W;
  localparam int AREA_W = ftta_pkg::AREA_W;
  localparam int DEPTH  = ftta_pkg::MAX_CELLS;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CLR     = 4'd1;
  localparam logic [3:0] ST_CNT_RD  = 4'd2;
  localparam logic [3:0] ST_CNT_IDX = 4'd3;
  localparam logic [3:0] ST_CNT_WR  = 4'd4;
  localparam logic [3:0] ST_SEED    = 4'd5;
  localparam logic [3:0] ST_KH_Q    = 4'd6;
  localparam logic [3:0] ST_KH_DS   = 4'd7;
  localparam logic [3:0] ST_KH_IDG  = 4'd8;
  localparam logic [3:0] ST_KH_WR   = 4'd9;
  localparam logic [3:0] ST_AC_Q    = 4'd10;
  localparam logic [3:0] ST_AC_DS   = 4'd11;
  localparam logic [3:0] ST_AC_RD   = 4'd12;
  localparam logic [3:0] ST_AC_WR   = 4'd13;
  localparam logic [3:0] ST_DONE    = 4'd14;

  // Memories.
  logic [DS_W-1:0]   ds_mem  [DEPTH];
  logic [OWN_W-1:0]  own_mem [DEPTH];
  logic [CNT_W-1:0]  ig_mem  [DEPTH];
  logic [IDX_W-1:0]  q_mem   [DEPTH];
  logic [AREA_W-1:0] acc_mem [DEPTH];

  logic [DS_W-1:0]   ds_rd;
  logic [OWN_W-1:0]  own_rd;
  logic [CNT_W-1:0]  ig_rd;
  logic [IDX_W-1:0]  q_rd;
  logic [AREA_W-1:0] acc_rd;

  logic              ds_we;
  logic [IDX_W-1:0]  ds_ra;
  logic [IDX_W-1:0]  own_ra;
  logic              ig_we;
  logic [IDX_W-1:0]  ig_wa, ig_ra;
  logic [CNT_W-1:0]  ig_wd;
  logic              q_we;
  logic [IDX_W-1:0]  q_wa, q_ra, q_wd;
  logic              acc_we;
  logic [IDX_W-1:0]  acc_wa, acc_ra;
  logic [AREA_W-1:0] acc_wd;

  // Control registers.
  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cell_count_r, cell_count_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] ordered_r, ordered_nxt;
  logic             cycle_r, cycle_nxt;
  logic [CNT_W-1:0] run_cells_r, run_cells_nxt;
  logic             clr_pend_r, clr_pend_nxt;
  logic             seed_pend_r, seed_pend_nxt;
  logic             out_strobe_r, out_strobe_nxt;

  // Payload registers.
  logic [IDX_W-1:0]  d_r, d_nxt;
  logic [AREA_W-1:0] a_r, a_nxt;
  logic [IDX_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [IDX_W-1:0]  seed_idx_r, seed_idx_nxt;
  logic              is_read_r, is_read_nxt;
  logic              entry_ok_r, entry_ok_nxt;
  logic              area_ok_r, area_ok_nxt;

  logic             accept;
  logic [CNT_W-1:0] n_sat;
  logic [CNT_W-1:0] ig_dec;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign n_sat  = (cell_count_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cell_count_r;
  assign ig_dec = ig_rd - CNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    cell_count_nxt = cfg_we ? cfg_wdata : cell_count_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    ordered_nxt    = ordered_r;
    cycle_nxt      = cycle_r;
    run_cells_nxt  = run_cells_r;
    clr_pend_nxt   = 1'b0;
    seed_pend_nxt  = 1'b0;
    out_strobe_nxt = 1'b0;
    d_nxt          = d_r;
    a_nxt          = a_r;
    clr_addr_nxt   = i_r[IDX_W-1:0];
    seed_idx_nxt   = i_r[IDX_W-1:0];
    is_read_nxt    = is_read_r;
    entry_ok_nxt   = entry_ok_r;
    area_ok_nxt    = area_ok_r;

    ds_we  = 1'b0;
    ds_ra  = i_r[IDX_W-1:0];
    own_ra = i_r[IDX_W-1:0];
    ig_we  = 1'b0;
    ig_wa  = i_r[IDX_W-1:0];
    ig_wd  = '0;
    ig_ra  = i_r[IDX_W-1:0];
    q_we   = 1'b0;
    q_wa   = tail_r[IDX_W-1:0];
    q_wd   = seed_idx_r;
    q_ra   = in_cell_index;
    acc_we = 1'b0;
    acc_wa = clr_addr_r;
    acc_wd = AREA_W'(own_rd);
    acc_ra = in_cell_index;

    // Finish the delayed copy of own area into the accumulator.
    if (clr_pend_r) begin
      acc_we = 1'b1;
    end

    // Append a seed whose in-degree came back zero.
    if (seed_pend_r && (ig_rd == '0)) begin
      q_we     = 1'b1;
      tail_nxt = tail_r + CNT_W'(1);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            ftta_pkg::OP_LOAD: begin
              ds_we = 1'b1;
            end
            ftta_pkg::OP_RUN: begin
              n_nxt         = n_sat;
              i_nxt         = '0;
              head_nxt      = '0;
              tail_nxt      = '0;
              state_nxt     = ST_CLR;
            end
            ftta_pkg::OP_READ: begin
              out_strobe_nxt = 1'b1;
              is_read_nxt    = 1'b1;
              entry_ok_nxt   = ({1'b0, in_cell_index} < ordered_r);
              area_ok_nxt    = ({1'b0, in_cell_index} < run_cells_r);
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLR: begin
        if (i_r < n_r) begin
          ig_we        = 1'b1;
          clr_pend_nxt = 1'b1;
          i_nxt        = i_r + CNT_W'(1);
        end else begin
          i_nxt     = '0;
          state_nxt = ST_CNT_RD;
        end
      end
      ST_CNT_RD: begin
        if (i_r < n_r) begin
          state_nxt = ST_CNT_IDX;
        end else begin
          i_nxt     = '0;
          state_nxt = ST_SEED;
        end
      end
      ST_CNT_IDX: begin
        if (ds_rd < n_r) begin
          ig_ra     = ds_rd[IDX_W-1:0];
          d_nxt     = ds_rd[IDX_W-1:0];
          state_nxt = ST_CNT_WR;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = ST_CNT_RD;
        end
      end
      ST_CNT_WR: begin
        ig_we     = 1'b1;
        ig_wa     = d_r;
        ig_wd     = ig_rd + CNT_W'(1);
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = ST_CNT_RD;
      end
      ST_SEED: begin
        if (i_r < n_r) begin
          seed_pend_nxt = 1'b1;
          i_nxt         = i_r + CNT_W'(1);
        end else begin
          state_nxt = ST_KH_Q;
        end
      end
      ST_KH_Q: begin
        if (head_r < tail_r) begin
          q_ra      = head_r[IDX_W-1:0];
          head_nxt  = head_r + CNT_W'(1);
          state_nxt = ST_KH_DS;
        end else begin
          ordered_nxt   = head_r;
          cycle_nxt     = (head_r != n_r);
          run_cells_nxt = n_r;
          i_nxt         = '0;
          state_nxt     = ST_AC_Q;
        end
      end
      ST_KH_DS: begin
        ds_ra     = q_rd;
        state_nxt = ST_KH_IDG;
      end
      ST_KH_IDG: begin
        if (ds_rd < n_r) begin
          ig_ra     = ds_rd[IDX_W-1:0];
          d_nxt     = ds_rd[IDX_W-1:0];
          state_nxt = ST_KH_WR;
        end else begin
          state_nxt = ST_KH_Q;
        end
      end
      ST_KH_WR: begin
        ig_we = 1'b1;
        ig_wa = d_r;
        ig_wd = ig_dec;
        // Last upstream neighbor gone: append the downstream cell.
        if ((ig_dec == '0) && (tail_r < n_r)) begin
          q_we     = 1'b1;
          q_wd     = d_r;
          tail_nxt = tail_r + CNT_W'(1);
        end
        state_nxt = ST_KH_Q;
      end
      ST_AC_Q: begin
        if (i_r < ordered_r) begin
          q_ra      = i_r[IDX_W-1:0];
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = ST_AC_DS;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_AC_DS: begin
        ds_ra     = q_rd;
        acc_ra    = q_rd;
        state_nxt = ST_AC_RD;
      end
      ST_AC_RD: begin
        if (ds_rd < n_r) begin
          acc_ra    = ds_rd[IDX_W-1:0];
          d_nxt     = ds_rd[IDX_W-1:0];
          a_nxt     = acc_rd;
          state_nxt = ST_AC_WR;
        end else begin
          state_nxt = ST_AC_Q;
        end
      end
      ST_AC_WR: begin
        acc_we    = 1'b1;
        acc_wa    = d_r;
        acc_wd    = ftta_pkg::sat_add(acc_rd, a_r);
        state_nxt = ST_AC_Q;
      end
      ST_DONE: begin
        out_strobe_nxt = 1'b1;
        is_read_nxt    = 1'b0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cell_count_r <= CNT_W'(DEPTH);
      n_r          <= '0;
      i_r          <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      ordered_r    <= '0;
      cycle_r      <= 1'b0;
      run_cells_r  <= '0;
      clr_pend_r   <= 1'b0;
      seed_pend_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cell_count_r <= cell_count_nxt;
      n_r          <= n_nxt;
      i_r          <= i_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      ordered_r    <= ordered_nxt;
      cycle_r      <= cycle_nxt;
      run_cells_r  <= run_cells_nxt;
      clr_pend_r   <= clr_pend_nxt;
      seed_pend_r  <= seed_pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r        <= d_nxt;
    a_r        <= a_nxt;
    clr_addr_r <= clr_addr_nxt;
    seed_idx_r <= seed_idx_nxt;
    is_read_r  <= is_read_nxt;
    entry_ok_r <= entry_ok_nxt;
    area_ok_r  <= area_ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (ds_we) begin
      ds_mem[in_cell_index]  <= in_downstream;
      own_mem[in_cell_index] <= in_cell_area;
    end
    ds_rd  <= ds_mem[ds_ra];
    own_rd <= own_mem[own_ra];
  end

  always_ff @(posedge clk) begin
    if (ig_we) begin
      ig_mem[ig_wa] <= ig_wd;
    end
    ig_rd <= ig_mem[ig_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    q_rd <= q_mem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    acc_rd <= acc_mem[acc_ra];
  end

  assign out_strobe           = out_strobe_r;
  assign out_order_entry      = (is_read_r && entry_ok_r) ? q_rd : '0;
  assign out_accumulated_area = (is_read_r && area_ok_r) ? acc_rd : '0;
  assign out_ordered_total    = ordered_r;
  assign out_cycle_found      = cycle_r;

  `ASSERT_NEXT(a_read_strobe, accept && (in_op == ftta_pkg::OP_READ), out_strobe)
  `ASSERT_NEXT(a_done_strobe, state_r == ST_DONE, out_strobe && !busy)
  `ASSERT_IMPL(a_head_tail, busy, (head_r <= tail_r) && (tail_r <= n_r))
  `ASSERT_IMPL(a_ordered_bound, 1'b1, ordered_r <= run_cells_r)

endmodule
